### rtl/rgbe_rle_pkg.sv
// ----------------------------------------------------------------------------
// RGBE scanline decoder package
// Operation codes, format codes, decoding constants and the result record
// shared by the decoder modules.
// ----------------------------------------------------------------------------
package rgbe_rle_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Scanline format codes.
  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_NEW     = 2'd1;
  localparam logic [1:0] FMT_OLD     = 2'd2;

  // Decoding constants.
  localparam logic [7:0] RUN_FLAG   = 8'd128;
  localparam logic [7:0] COUNT_MASK = 8'd127;
  localparam logic [7:0] NEW_TAG    = 8'd2;
  localparam logic [7:0] MARK_BYTE  = 8'd1;
  localparam logic [4:0] SHIFT_STEP = 5'd8;
  localparam logic [4:0] SHIFT_MAX  = 5'd24;

  // Line width after reset.
  localparam logic [12:0] LINE_WIDTH_RESET = 13'd4096;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_exponent;
    logic       line_complete;
    logic [1:0] line_format;
    logic       overrun;
  } result_t;

endpackage

### rtl/rgbe_rle_if.sv
// ----------------------------------------------------------------------------
// RGBE scanline decoder channels
// Valid/ready channels for input transactions and for result transactions.
// ----------------------------------------------------------------------------
interface rgbe_rle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  data_byte;
  logic [11:0] pixel_index;

  modport source (output valid, output operation, output data_byte, output pixel_index,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input pixel_index,
                output ready);
endinterface

interface rgbe_rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_exponent;
  logic       line_complete;
  logic [1:0] line_format;
  logic       overrun;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  output pixel_exponent, output line_complete, output line_format,
                  output overrun, input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                input pixel_exponent, input line_complete, input line_format,
                input overrun, output ready);
endinterface

### rtl/rgbe_rle_store.sv
// ----------------------------------------------------------------------------
// RGBE line store
// Synchronous pixel memory with byte-lane write enables and one registered
// read port.
// ----------------------------------------------------------------------------
module rgbe_rle_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [3:0]    wr_be,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] store_mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_be[i]) begin
          store_mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rgbe_rle_engine.sv
// ----------------------------------------------------------------------------
// RGBE scanline decode engine
// Holds the line decoding state, turns data bytes into store writes and reads
// into a store read, and sequences run and repeat fills one entry a cycle.
// ----------------------------------------------------------------------------
module rgbe_rle_engine #(
  parameter int MAX_WIDTH = 4096,
  parameter int PW        = 13,
  parameter int AW        = 12,
  parameter int CW        = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_data_byte,
  input  logic [11:0]           in_pixel_index,
  input  logic                  res_ready,
  output logic                  res_push,
  output rgbe_rle_pkg::result_t res,
  output logic                  mem_we,
  output logic [3:0]            mem_be,
  output logic [AW-1:0]         mem_waddr,
  output logic [31:0]           mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [31:0]           mem_rdata
);

  import rgbe_rle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  function automatic logic [PW-1:0] eff_width(input logic [12:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (v == 13'd0) begin
      eff_width = PW'(1);
    end else if (ve > CW'(MAX_WIDTH)) begin
      eff_width = PW'(MAX_WIDTH);
    end else begin
      eff_width = ve[PW-1:0];
    end
  endfunction

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] eff_w_r;
  logic [23:0]   lead_r, lead_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          run_r, run_nxt;
  logic [4:0]    shift_r, shift_nxt;
  logic          ovr_r, ovr_nxt;
  logic          done_r, done_nxt;
  logic [PW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [AW-1:0] fill_addr_r, fill_addr_nxt;
  logic [3:0]    fill_be_r, fill_be_nxt;
  logic [7:0]    fill_byte_r, fill_byte_nxt;
  logic          fill_mem_r, fill_mem_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          accept;
  logic [23:0]   b_lead;
  logic [1:0]    b_phase, b_mode, b_ch;
  logic [PW-1:0] b_wp, room, fill_n, prev_pos;
  logic [7:0]    b_pend;
  logic          b_run, b_ovr;
  logic [4:0]    b_shift;
  logic [31:0]   fill_req, px, res_pix;
  logic          fill_over;
  logic [3:0]    lane_be;
  logic [CW-1:0] idx_ext;

  assign in_ready = (state_r == ST_IDLE) && res_ready;
  assign accept   = in_valid && in_ready;

  // A byte that follows a finished line starts a fresh line.
  assign b_lead  = done_r ? 24'd0 : lead_r;
  assign b_phase = done_r ? 2'd0 : phase_r;
  assign b_mode  = done_r ? FMT_UNKNOWN : mode_r;
  assign b_ch    = done_r ? 2'd0 : ch_r;
  assign b_wp    = done_r ? '0 : wp_r;
  assign b_pend  = done_r ? 8'd0 : pend_r;
  assign b_run   = done_r ? 1'b0 : run_r;
  assign b_shift = done_r ? 5'd0 : shift_r;
  assign b_ovr   = done_r ? 1'b0 : ovr_r;

  assign px       = {in_data_byte, b_lead};
  assign room     = (b_wp < eff_w_r) ? (eff_w_r - b_wp) : '0;
  assign prev_pos = b_wp - PW'(1);
  assign lane_be  = 4'b0001 << b_ch;
  assign idx_ext  = CW'(in_pixel_index);

  // Run length in new RLE, or the repeat count of an old-format marker.
  assign fill_req  = (b_mode == FMT_NEW) ? 32'(b_pend) : (32'(in_data_byte) << b_shift);
  assign fill_over = fill_req > 32'(room);
  assign fill_n    = fill_over ? room : fill_req[PW-1:0];

  always_comb begin
    state_nxt     = state_r;
    lead_nxt      = lead_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    ch_nxt        = ch_r;
    wp_nxt        = wp_r;
    pend_nxt      = pend_r;
    run_nxt       = run_r;
    shift_nxt     = shift_r;
    ovr_nxt       = ovr_r;
    done_nxt      = done_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_addr_nxt = fill_addr_r;
    fill_be_nxt   = fill_be_r;
    fill_byte_nxt = fill_byte_r;
    fill_mem_nxt  = fill_mem_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_be        = 4'h0;
    mem_waddr     = b_wp[AW-1:0];
    mem_wdata     = {4{in_data_byte}};
    mem_re        = 1'b0;
    mem_raddr     = prev_pos[AW-1:0];
    res_push      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_DATA: begin
              lead_nxt  = b_lead;
              phase_nxt = b_phase;
              mode_nxt  = b_mode;
              ch_nxt    = b_ch;
              wp_nxt    = b_wp;
              pend_nxt  = b_pend;
              run_nxt   = b_run;
              shift_nxt = b_shift;
              ovr_nxt   = b_ovr;
              done_nxt  = 1'b0;
              res_push  = 1'b1;
              if (b_mode == FMT_NEW) begin
                if (b_pend == 8'd0) begin
                  if (in_data_byte > RUN_FLAG) begin
                    run_nxt  = 1'b1;
                    pend_nxt = in_data_byte & COUNT_MASK;
                  end else begin
                    run_nxt  = 1'b0;
                    pend_nxt = in_data_byte;
                  end
                end else begin
                  if (b_run) begin
                    if (fill_over) begin
                      ovr_nxt = 1'b1;
                    end
                    wp_nxt   = b_wp + fill_n;
                    pend_nxt = 8'd0;
                    if (fill_n != '0) begin
                      res_push      = 1'b0;
                      state_nxt     = ST_FILL;
                      fill_cnt_nxt  = fill_n;
                      fill_addr_nxt = b_wp[AW-1:0];
                      fill_be_nxt   = lane_be;
                      fill_byte_nxt = in_data_byte;
                      fill_mem_nxt  = 1'b0;
                    end
                  end else begin
                    if (b_wp < eff_w_r) begin
                      mem_we = 1'b1;
                      mem_be = lane_be;
                      wp_nxt = b_wp + PW'(1);
                    end else begin
                      ovr_nxt = 1'b1;
                    end
                    pend_nxt = b_pend - 8'd1;
                  end
                  // A channel ends once its counts are used up at the line width.
                  if (pend_nxt == 8'd0 && wp_nxt >= eff_w_r) begin
                    wp_nxt = '0;
                    if (b_ch == 2'd3) begin
                      done_nxt = 1'b1;
                    end else begin
                      ch_nxt = b_ch + 2'd1;
                    end
                  end
                end
              end else if (b_phase != 2'd3) begin
                case (b_phase)
                  2'd0:    lead_nxt[7:0]   = in_data_byte;
                  2'd1:    lead_nxt[15:8]  = in_data_byte;
                  default: lead_nxt[23:16] = in_data_byte;
                endcase
                phase_nxt = b_phase + 2'd1;
              end else begin
                phase_nxt = 2'd0;
                lead_nxt  = 24'd0;
                if (b_mode == FMT_UNKNOWN) begin
                  mem_we    = 1'b1;
                  mem_be    = 4'hF;
                  mem_waddr = '0;
                  mem_wdata = px;
                  if (px[7:0] == NEW_TAG && px[15:8] == NEW_TAG && px[23:16] < RUN_FLAG) begin
                    mode_nxt = FMT_NEW;
                    ch_nxt   = 2'd0;
                    wp_nxt   = '0;
                    pend_nxt = 8'd0;
                    run_nxt  = 1'b0;
                  end else begin
                    mode_nxt  = FMT_OLD;
                    wp_nxt    = PW'(1);
                    shift_nxt = 5'd0;
                    if (eff_w_r == PW'(1)) begin
                      done_nxt = 1'b1;
                    end
                  end
                end else if (b_wp >= eff_w_r) begin
                  done_nxt = 1'b1;
                end else begin
                  if (px[7:0] == MARK_BYTE && px[15:8] == MARK_BYTE &&
                      px[23:16] == MARK_BYTE) begin
                    if (fill_over) begin
                      ovr_nxt = 1'b1;
                    end
                    wp_nxt    = b_wp + fill_n;
                    shift_nxt = (b_shift < SHIFT_MAX) ? (b_shift + SHIFT_STEP) : b_shift;
                    if (fill_n != '0) begin
                      // Fetch the previous pixel; it arrives in the first fill cycle.
                      mem_re        = 1'b1;
                      res_push      = 1'b0;
                      state_nxt     = ST_FILL;
                      fill_cnt_nxt  = fill_n;
                      fill_addr_nxt = b_wp[AW-1:0];
                      fill_be_nxt   = 4'hF;
                      fill_mem_nxt  = 1'b1;
                    end
                  end else begin
                    mem_we    = 1'b1;
                    mem_be    = 4'hF;
                    mem_wdata = px;
                    wp_nxt    = b_wp + PW'(1);
                    shift_nxt = 5'd0;
                  end
                  if (wp_nxt >= eff_w_r) begin
                    done_nxt = 1'b1;
                  end
                end
              end
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = idx_ext[AW-1:0];
              rd_ok_nxt = idx_ext < CW'(MAX_WIDTH);
              state_nxt = ST_READ;
            end
            OP_RESTART: begin
              lead_nxt  = 24'd0;
              phase_nxt = 2'd0;
              mode_nxt  = FMT_UNKNOWN;
              ch_nxt    = 2'd0;
              wp_nxt    = '0;
              pend_nxt  = 8'd0;
              run_nxt   = 1'b0;
              shift_nxt = 5'd0;
              ovr_nxt   = 1'b0;
              done_nxt  = 1'b0;
              res_push  = 1'b1;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        mem_we        = 1'b1;
        mem_be        = fill_be_r;
        mem_waddr     = fill_addr_r;
        mem_wdata     = fill_mem_r ? mem_rdata : {4{fill_byte_r}};
        fill_addr_nxt = fill_addr_r + AW'(1);
        fill_cnt_nxt  = fill_cnt_r - PW'(1);
        if (fill_cnt_r == PW'(1)) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Status fields show the line state after the transaction.
  assign res_pix = (state_r == ST_READ && rd_ok_r) ? mem_rdata : 32'd0;
  assign res.pixel_red      = res_pix[7:0];
  assign res.pixel_green    = res_pix[15:8];
  assign res.pixel_blue     = res_pix[23:16];
  assign res.pixel_exponent = res_pix[31:24];
  assign res.line_complete  = done_nxt;
  assign res.line_format    = mode_nxt;
  assign res.overrun        = ovr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eff_w_r <= eff_width(LINE_WIDTH_RESET);
      lead_r  <= 24'd0;
      phase_r <= 2'd0;
      mode_r  <= FMT_UNKNOWN;
      ch_r    <= 2'd0;
      wp_r    <= '0;
      pend_r  <= 8'd0;
      run_r   <= 1'b0;
      shift_r <= 5'd0;
      ovr_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        eff_w_r <= eff_width(cfg_wdata);
      end
      lead_r  <= lead_nxt;
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      ch_r    <= ch_nxt;
      wp_r    <= wp_nxt;
      pend_r  <= pend_nxt;
      run_r   <= run_nxt;
      shift_r <= shift_nxt;
      ovr_r   <= ovr_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_cnt_r  <= fill_cnt_nxt;
    fill_addr_r <= fill_addr_nxt;
    fill_be_r   <= fill_be_nxt;
    fill_byte_r <= fill_byte_nxt;
    fill_mem_r  <= fill_mem_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

endmodule

### rtl/rgbe_rle_outbuf.sv
// ----------------------------------------------------------------------------
// RGBE result buffer
// Two-entry result queue whose head is the output register, so the engine
// can finish one more transaction while the receiver stalls.
// ----------------------------------------------------------------------------
module rgbe_rle_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rgbe_rle_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rgbe_rle_pkg::result_t out_data
);

  import rgbe_rle_pkg::*;

  result_t head_r, head_nxt;
  result_t tail_r, tail_nxt;
  logic    v0_r, v0_nxt;
  logic    v1_r, v1_nxt;
  logic    pop;

  assign pop = v0_r && out_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    if (pop) begin
      if (v1_r) begin
        head_nxt = tail_r;
        v1_nxt   = 1'b0;
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        v0_nxt = 1'b0;
      end
    end else if (push) begin
      if (!v0_r) begin
        head_nxt = push_data;
        v0_nxt   = 1'b1;
      end else begin
        tail_nxt = push_data;
        v1_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_data  = head_r;

endmodule

### rtl/rgbe_scanline_rle_decoder.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder
// Decodes Radiance RGBE scanlines from a byte stream into a pixel line store
// and answers pixel reads by index.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one transaction per operation: a data byte of the encoded
//   scanline, a pixel read at pixel_index, or an abandon-and-restart. Every
//   input transaction yields exactly one result transaction on out_chan, in
//   order, carrying the read pixel (zero unless a read) and the line status
//   after that transaction. cfg_we/cfg_wdata set the line width.
//   Completion: a data byte that writes at most one entry, a restart or an
//   unused code is finished in the cycle it is accepted; a read is answered
//   through the registered store read port. A run (new RLE) or a repeat
//   marker (old format) writes one store entry per cycle through the single
//   write port in the fill state. Inputs are accepted one at a time.
//   Results sit in a two-entry queue; while the receiver stalls, one more
//   transaction is accepted and finished, then in_chan.ready drops.
//   Reset clears the line state and sets the width to its default; the
//   store contents are undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rgbe_rle_in_if.sink           in_chan,
  rgbe_rle_out_if.source        out_chan,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_wdata
);

  import rgbe_rle_pkg::*;

  localparam int PW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (PW > 13) ? PW : 13;

  logic          mem_we, mem_re;
  logic [3:0]    mem_be;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          res_push, buf_full, in_acc;
  result_t       res, out_res;

  rgbe_rle_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_be   (mem_be),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  rgbe_rle_engine #(
    .MAX_WIDTH (MAX_WIDTH),
    .PW        (PW),
    .AW        (AW),
    .CW        (CW)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_operation   (in_chan.operation),
    .in_data_byte   (in_chan.data_byte),
    .in_pixel_index (in_chan.pixel_index),
    .res_ready      (!buf_full),
    .res_push       (res_push),
    .res            (res),
    .mem_we         (mem_we),
    .mem_be         (mem_be),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  rgbe_rle_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_res)
  );

  assign out_chan.pixel_red      = out_res.pixel_red;
  assign out_chan.pixel_green    = out_res.pixel_green;
  assign out_chan.pixel_blue     = out_res.pixel_blue;
  assign out_chan.pixel_exponent = out_res.pixel_exponent;
  assign out_chan.line_complete  = out_res.line_complete;
  assign out_chan.line_format    = out_res.line_format;
  assign out_chan.overrun        = out_res.overrun;

  assign in_acc = in_chan.valid && in_chan.ready;

  // The engine must never finish a transaction into a full result queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !buf_full)
    else $error("result pushed into a full queue");

  // A read transaction is answered from the store in the cycle after acceptance.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.operation == OP_READ) |=> res_push)
    else $error("read result not produced on time");

  // A restart finishes at once and reports a fresh line.
  a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.operation == OP_RESTART) |->
      (res_push && res.line_format == FMT_UNKNOWN && !res.line_complete && !res.overrun))
    else $error("restart did not clear the line status");

endmodule
